[rtl/iss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;
   localparam int OP_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   // token and running "already matched" flag, handed cell to cell
   typedef struct packed {
      logic tok;
      logic seen;
   } link_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic              rm;
      logic              wr;
      logic [DATA_W-1:0] value;
   } cell_bus_type;

endpackage

`default_nettype wire

[rtl/iss_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module iss_cell #(
   parameter int INDEX  = 0,
   parameter int HELD_W = 5
) (
   input  wire                           clock,
   input  wire                           reset,
   input  iss_pkg::cell_bus_type         bus,
   input  wire  [HELD_W-1:0]             held,
   input  iss_pkg::link_type             link_in,
   output iss_pkg::link_type             link_out,
   input  wire  [iss_pkg::DATA_W-1:0]    next_entry,
   output logic [iss_pkg::DATA_W-1:0]    entry
);

   logic [iss_pkg::DATA_W-1:0] entry_ff;
   logic [iss_pkg::DATA_W-1:0] entry_in;
   logic                       tok_ff;
   logic                       seen_ff;
   logic                       valid;
   logic                       match;

   assign valid = held > HELD_W'(INDEX);
   assign match = valid && (entry_ff == bus.value);

   always_comb begin
      entry_in = entry_ff;
      if (bus.wr && (held == HELD_W'(INDEX))) begin
         entry_in = bus.value;
      end else if (tok_ff && bus.rm && (seen_ff || match)) begin
         // close the gap: take the right neighbor's entry
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      seen_ff  <= link_in.seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= link_in.tok;
      end
   end

   assign link_out.tok  = tok_ff;
   assign link_out.seen = seen_ff || match;
   assign entry         = entry_ff;

endmodule

`default_nettype wire

[rtl/integer_set_store_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Set store for up to CAPACITY distinct signed 32-bit values.
// Request channel (req_valid / req_stall, req_op, req_value): op insert, remove
// or query (the unused op code acts as a query). Response channel (rsp_valid /
// rsp_stall): was_member, count after the step, is_empty, status (1 = insert
// rejected, store full). One response per request, in order.
// The entries sit in a row of cells. A token walks the row one cell per cycle,
// carrying a flag that is set once a cell matched; on remove, every cell at
// or past the match takes its right neighbor's value as the token passes.
// Insert writes the slot at the current count once the walk has shown the
// value absent.
// Order: the token passes each cell's register in turn, then fin_ff, then the
// response register; a new request is taken only after the walk has finished.
// req_stall stays high from the accept until the response is loaded.
// A stalled response holds; a finished walk waits until the output register
// frees, so nothing is lost. Reset clears the count (empty set) and the
// control; entry contents need no reset.
module integer_set_store_unit #(
   parameter int CAPACITY = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [iss_pkg::OP_W-1:0]         req_op,
   input  wire  signed [iss_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_was_member,
   output logic [iss_pkg::COUNT_W-1:0]      rsp_count,
   output logic                             rsp_is_empty,
   output logic                             rsp_status
);

   localparam int HW = $clog2(CAPACITY + 1);

   // control
   logic                       busy_ff;
   logic                       busy_in;
   logic                       fin_ff;
   logic                       fin_in;
   logic                       member_ff;
   iss_pkg::op_type            op_ff;
   logic [iss_pkg::DATA_W-1:0] value_ff;
   logic [HW-1:0]              held_ff;
   logic [HW-1:0]              held_in;

   // response register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_member_ff;
   logic [HW-1:0]              rsp_held_ff;
   logic                       rsp_status_ff;

   logic                       accept;
   logic                       finish;
   logic                       full;
   logic                       status_in;
   logic                       wr_en;

   iss_pkg::cell_bus_type      bus;
   iss_pkg::link_type          link  [0:CAPACITY];
   logic [iss_pkg::DATA_W-1:0] entry [0:CAPACITY-1];

   assign accept = req_valid && !busy_ff;
   // finish the walk only when the response register is free
   assign finish = fin_ff && !(rsp_valid_ff && rsp_stall);
   assign full   = held_ff == HW'(CAPACITY);

   // decide the step once membership is known
   always_comb begin
      held_in   = held_ff;
      status_in = 1'b0;
      wr_en     = 1'b0;
      case (op_ff)
         iss_pkg::OP_INSERT: begin
            if (!member_ff) begin
               if (!full) begin
                  wr_en   = finish;
                  held_in = held_ff + HW'(1);
               end else begin
                  status_in = 1'b1;
               end
            end
         end
         iss_pkg::OP_REMOVE: begin
            if (member_ff) begin
               held_in = held_ff - HW'(1);
            end
         end
         default: begin
            held_in = held_ff;
         end
      endcase
   end

   assign busy_in      = accept || (busy_ff && !finish);
   assign fin_in       = link[CAPACITY].tok || (fin_ff && !finish);
   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            held_ff <= held_in;
         end
      end
   end

   // payload: capture the request, the walk outcome and the response
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= iss_pkg::op_type'(req_op);
         value_ff <= $unsigned(req_value);
      end
      if (link[CAPACITY].tok) begin
         member_ff <= link[CAPACITY].seen;
      end
      if (finish) begin
         rsp_member_ff <= member_ff;
         rsp_held_ff   <= held_in;
         rsp_status_ff <= status_in;
      end
   end

   // broadcast to the row; inject the token at cell 0 on accept
   assign bus.rm    = op_ff == iss_pkg::OP_REMOVE;
   assign bus.wr    = wr_en;
   assign bus.value = value_ff;

   assign link[0].tok  = accept;
   assign link[0].seen = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [iss_pkg::DATA_W-1:0] nxt;
         if (gi < CAPACITY - 1) begin : g_mid
            assign nxt = entry[gi+1];
         end else begin : g_end
            // last slot falls beyond the count after a remove
            assign nxt = entry[gi];
         end
         iss_cell #(
            .INDEX  (gi),
            .HELD_W (HW)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .bus        (bus),
            .held       (held_ff),
            .link_in    (link[gi]),
            .link_out   (link[gi+1]),
            .next_entry (nxt),
            .entry      (entry[gi])
         );
      end
   endgenerate

   // count field: mask or extend the internal count to five bits
   generate
      if (HW >= iss_pkg::COUNT_W) begin : g_cnt_trunc
         assign rsp_count = rsp_held_ff[iss_pkg::COUNT_W-1:0];
      end else begin : g_cnt_ext
         assign rsp_count = {{(iss_pkg::COUNT_W-HW){1'b0}}, rsp_held_ff};
      end
   endgenerate

   assign req_stall      = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_was_member = rsp_member_ff;
   assign rsp_is_empty   = rsp_held_ff == '0;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/iss_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module iss_checker #(
   parameter int CAPACITY = 16
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_stall,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire                              rsp_was_member,
   input wire [iss_pkg::COUNT_W-1:0]       rsp_count,
   input wire                              rsp_is_empty,
   input wire                              rsp_status
);

   logic [iss_pkg::COUNT_W-1:0] cap_count;

   assign cap_count = iss_pkg::COUNT_W'(CAPACITY);

   // one request in flight: an accept blocks the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while one is in flight");

   // a rejected insert only happens on an absent value with the store full
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (!rsp_was_member && rsp_count == cap_count))
      else $error("full status without a full store");

   // empty flag agrees with the count while the count cannot wrap
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && CAPACITY < 32) |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   // no response without a request before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in flight");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_count)
                                    && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind integer_set_store_unit iss_checker #(.CAPACITY(CAPACITY)) u_iss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_was_member (rsp_was_member),
   .rsp_count      (rsp_count),
   .rsp_is_empty   (rsp_is_empty),
   .rsp_status     (rsp_status)
);

`default_nettype wire

[dv/set_membership_checker.sv]
`timescale 1ns / 1ps

module set_membership_checker #(
   parameter int CAPACITY = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  wire  [iss_pkg::OP_W-1:0]           req_op,
   input  wire  signed [iss_pkg::DATA_W-1:0]  req_value,
   input  wire                                rsp_valid,
   input  wire                                rsp_stall,
   input  wire                                rsp_was_member,
   input  wire  [iss_pkg::COUNT_W-1:0]        rsp_count,
   input  wire                                rsp_is_empty,
   input  wire                                rsp_status,
   output int                                 failures,
   output int                                 pending,
   output int                                 responses_checked,
   output int                                 full_rejects
);

   typedef struct packed {
      logic                         was_member;
      logic [iss_pkg::COUNT_W-1:0]  count;
      logic                         is_empty;
      logic                         status;
   } set_result_type;

   logic signed [iss_pkg::DATA_W-1:0] set_members[$];
   set_result_type                    expected_results[$];
   int                                fail_total = 0;
   int                                check_total = 0;
   int                                reject_total = 0;

   // Apply one request to the shadow set and return the response it must give.
   function automatic set_result_type apply_set_op(input logic [iss_pkg::OP_W-1:0] op,
                                                   input logic signed [iss_pkg::DATA_W-1:0] val);
      set_result_type r;
      int             slot;
      slot = -1;
      foreach (set_members[i]) begin
         if (slot < 0 && set_members[i] == val) slot = i;
      end
      r.was_member = (slot >= 0);
      r.status     = 1'b0;
      case (op)
         iss_pkg::OP_INSERT: begin
            if (slot < 0) begin
               if (set_members.size() < CAPACITY) set_members.push_back(val);
               else r.status = 1'b1;
            end
         end
         iss_pkg::OP_REMOVE: begin
            if (slot >= 0) set_members.delete(slot);
         end
         default: ;
      endcase
      r.count    = iss_pkg::COUNT_W'(set_members.size());
      r.is_empty = (set_members.size() == 0);
      return r;
   endfunction

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: rsp_%s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      set_result_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response with nothing expected: was_member %0d count %0d",
                        $time, rsp_was_member, rsp_count);
               fail_total++;
            end else begin
               exp_r = expected_results.pop_front();
               check_field("was_member", int'(exp_r.was_member), int'(rsp_was_member));
               check_field("count", int'(exp_r.count), int'(rsp_count));
               check_field("is_empty", int'(exp_r.is_empty), int'(rsp_is_empty));
               check_field("status", int'(exp_r.status), int'(rsp_status));
               check_total++;
            end
         end
         if (req_valid && !req_stall) begin
            exp_r = apply_set_op(req_op, req_value);
            if (exp_r.status) reject_total++;
            expected_results.push_back(exp_r);
         end
      end
      failures          <= fail_total;
      pending           <= expected_results.size();
      responses_checked <= check_total;
      full_rejects      <= reject_total;
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int                     CAPACITY      = 16;
   localparam int                     WATCHDOG_MAX  = 5000;
   localparam int                     PHASE_ITEMS   = 480;
   localparam int                     POOL_SIZE     = 20;
   // spare op code: the block must treat it as a query
   localparam logic [iss_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam logic signed [31:0]     INT_MIN       = 32'sh8000_0000;
   localparam logic signed [31:0]     INT_MAX       = 32'sh7FFF_FFFF;

   typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_type;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [iss_pkg::OP_W-1:0]           req_op    = iss_pkg::OP_QUERY;
   logic signed [iss_pkg::DATA_W-1:0]  req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_was_member;
   logic [iss_pkg::COUNT_W-1:0]        rsp_count;
   logic                               rsp_is_empty;
   logic                               rsp_status;

   int                                 failures;
   int                                 pending;
   int                                 responses_checked;
   int                                 full_rejects;

   int                                 idle_pct  = 0;
   int                                 stall_pct = 0;
   int                                 requests_sent = 0;
   int                                 quiet_cycles = 0;
   logic signed [31:0]                 value_pool[POOL_SIZE];

   always #4 clock = ~clock;

   integer_set_store_unit #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_was_member (rsp_was_member),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_status     (rsp_status)
   );

   set_membership_checker #(
      .CAPACITY(CAPACITY)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_was_member    (rsp_was_member),
      .rsp_count         (rsp_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_status        (rsp_status),
      .failures          (failures),
      .pending           (pending),
      .responses_checked (responses_checked),
      .full_rejects      (full_rejects)
   );

   // Back-pressure the response side: redraw the stall every cycle.
   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // Watchdog: count cycles with no handshake on either channel; the walk
   // through the cell row plus a long response stall stays far below the limit.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_MAX);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Present one request, idling first at the current sender rate, and hold
   // it until the block takes it. Valid is lowered only on idle cycles, so
   // back-to-back requests never see a low-high pair in one time step.
   task automatic send_request(input logic [iss_pkg::OP_W-1:0] op,
                               input logic signed [31:0] val);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= val;
      @(posedge clock);
      // hold the payload while the block stalls
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // Refill the value pool: a few more values than the set can hold, so both
   // full and empty states come up; now and then seed the extremes, 0 and -1.
   task automatic refill_pool();
      foreach (value_pool[i]) value_pool[i] = $urandom();
      if ($urandom_range(1)) value_pool[0] = INT_MIN;
      if ($urandom_range(1)) value_pool[1] = INT_MAX;
      if ($urandom_range(3) == 0) value_pool[2] = 0;
      if ($urandom_range(3) == 0) value_pool[3] = -1;
   endtask

   task automatic run_phase(input int sender_idle, input int receiver_stall);
      trend_type                    trend;
      int                           pick;
      int                           ins_pct;
      int                           rm_pct;
      logic [iss_pkg::OP_W-1:0]     op;
      logic signed [31:0]           val;
      trend     = TREND_MIXED;
      ins_pct   = 40;
      rm_pct    = 35;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      refill_pool();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         // swing the set between full and empty in bursts
         if (n % 40 == 0) begin
            trend = trend_type'($urandom_range(2));
            case (trend)
               TREND_FILL:  begin ins_pct = 75; rm_pct = 10; end
               TREND_DRAIN: begin ins_pct = 15; rm_pct = 70; end
               default:     begin ins_pct = 40; rm_pct = 35; end
            endcase
         end
         pick = $urandom_range(99);
         if (pick < ins_pct) op = iss_pkg::OP_INSERT;
         else if (pick < ins_pct + rm_pct) op = iss_pkg::OP_REMOVE;
         else if (pick < 95) op = iss_pkg::OP_QUERY;
         else op = OP_UNUSED;
         // mostly pool values so hits are common; some stray values as noise
         if ($urandom_range(19) == 0) val = $urandom();
         else val = value_pool[$urandom_range(POOL_SIZE - 1)];
         send_request(op, val);
      end
   endtask

   initial begin
      // hold reset, then release it at a rising edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, no idling: extremes, duplicates, absent removes, the
      // spare op code, a full store, and removal at both ends of the table.
      send_request(iss_pkg::OP_QUERY, 32'sd5);
      send_request(iss_pkg::OP_REMOVE, 32'sd5);
      send_request(iss_pkg::OP_INSERT, INT_MIN);
      send_request(iss_pkg::OP_INSERT, INT_MAX);
      send_request(iss_pkg::OP_INSERT, 32'sd0);
      send_request(iss_pkg::OP_INSERT, -32'sd1);
      send_request(iss_pkg::OP_INSERT, -32'sd1);
      send_request(iss_pkg::OP_QUERY, INT_MAX);
      send_request(OP_UNUSED, 32'sd0);
      send_request(iss_pkg::OP_REMOVE, 32'sd0);
      send_request(iss_pkg::OP_REMOVE, 32'sd0);
      for (int i = 0; i < CAPACITY - 3; i++) send_request(iss_pkg::OP_INSERT, 32'sh1000 + i);
      send_request(iss_pkg::OP_INSERT, 32'sh5A5A_A5A5);
      send_request(iss_pkg::OP_INSERT, INT_MAX);
      send_request(iss_pkg::OP_REMOVE, INT_MIN);
      send_request(iss_pkg::OP_REMOVE, 32'sh1000 + CAPACITY - 4);
      send_request(iss_pkg::OP_QUERY, INT_MIN);

      // Random part over the four idle/stall phases.
      run_phase(0, 0);
      run_phase(69, 0);
      run_phase(0, 69);
      run_phase(21, 21);

      // drop valid and let the response side run freely
      req_valid <= 1'b0;
      stall_pct = 0;
      while (pending != 0) @(posedge clock);
      repeat (CAPACITY + 4) @(posedge clock);

      $display("Sent %0d requests across four idle/stall phases; %0d responses checked.",
               requests_sent, responses_checked);
      $display("Inserts rejected on a full set: %0d.", full_rejects);
      if (failures == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
rtl/iss_pkg.sv
rtl/iss_cell.sv
rtl/integer_set_store_unit.sv
rtl/iss_checker.sv
dv/set_membership_checker.sv
dv/testbench.sv
